[rtl/leg_height_leveler_core_assert.svh]
// Assertion macros for the port-level checker of the leg height leveller.
// Needs nothing else; each macro expands to one labelled concurrent assertion.
`ifndef LEG_HEIGHT_LEVELER_CORE_ASSERT_SVH
`define LEG_HEIGHT_LEVELER_CORE_ASSERT_SVH

// Same-cycle implication, switched off while reset is high.
`define LHL_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("leveller assertion failed");

// Next-cycle implication, switched off while reset is high.
`define LHL_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("leveller assertion failed");

// Next-cycle implication that is also checked across reset.
`define LHL_ASSERT_NXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("leveller assertion failed");

`endif

[rtl/lhl_pkg.sv]
// Package of the leg height leveller: widths, constants, types and the
// tangent table builder. Depends on nothing.
package lhl_pkg;

   // Field widths
   localparam int ANGLE_W = 17;
   localparam int LEN_W   = 16;
   localparam int REACH_W = 14;
   localparam int LEG_W   = 2;
   localparam int CSR_W   = 16;
   localparam int CSR_IDX_W = 2;

   // Angle scale: 1/128 degree
   localparam int QUARTER_TURN = 11520;
   localparam int HALF_TURN    = 2 * QUARTER_TURN;
   localparam int FULL_TURN    = 4 * QUARTER_TURN;
   localparam int TWO_TURNS    = 2 * FULL_TURN;
   localparam int FOUR_TURNS   = 2 * TWO_TURNS;

   localparam int WRAP_W = $clog2(4 * FULL_TURN) + 1;
   localparam int RED_W  = $clog2(TWO_TURNS);
   localparam int TURN_W = $clog2(FULL_TURN);
   localparam int MAG_W  = $clog2(QUARTER_TURN + 1);

   localparam int PITCH_BIAS = 3 * FULL_TURN;
   localparam int ROLL_BIAS  = 3 * FULL_TURN - HALF_TURN;

   // Tangent table
   localparam int TAN_ENTRIES = 1024;
   localparam int TAB_AW      = $clog2(TAN_ENTRIES);
   localparam int IDX_W       = $clog2(TAN_ENTRIES + 1);
   localparam int TAN_LIMIT   = 4194304;
   localparam int TAN_W       = $clog2(TAN_LIMIT + 1);
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam longint unsigned ONE_Q30     = 64'd1073741824;

   // Index = floor(mag * TAN_ENTRIES / QUARTER_TURN) by a rounded-up
   // reciprocal; exact while mag * QUARTER_TURN stays below 2**IDX_SHIFT.
   localparam int IDX_SHIFT = 2 * MAG_W;
   localparam longint unsigned IDX_MUL =
      ((longint'(TAN_ENTRIES) << IDX_SHIFT) + longint'(QUARTER_TURN) - 1)
      / longint'(QUARTER_TURN);
   localparam int IDX_MUL_W  = $clog2(IDX_MUL + 1);
   localparam int IDX_PROD_W = MAG_W + IDX_MUL_W;

   // Lever arithmetic
   localparam int ARM_W     = LEN_W + 1;
   localparam int TANS_W    = TAN_W + 1;
   localparam int PROD_W    = ARM_W + TANS_W;
   localparam int SUM_W     = PROD_W + 1;
   localparam int FRAC_BITS = 16;
   localparam int DZ_W      = SUM_W - FRAC_BITS;
   localparam int HT_W      = DZ_W + 1;

   // Register reset values
   localparam int Z_FLOOR_RESET      = -3520;
   localparam int Z_CEILING_RESET    = -1280;
   localparam int REACH_OFFSET_RESET = 1120;

   // Pipeline
   localparam int NUM_STAGES    = 9;
   localparam int OUTSTANDING_W = $clog2(NUM_STAGES + 2);
   localparam int NUM_LANES     = 2;
   localparam int LANE_PITCH    = 0;
   localparam int LANE_ROLL     = 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_Z_FLOOR      = 2'd0,
      CSR_Z_CEILING    = 2'd1,
      CSR_REACH_OFFSET = 2'd2
   } csr_index_type;

   // Load strobes of the pipeline registers, first stage in bit 0.
   typedef struct packed {
      logic result;
      logic height;
      logic sum;
      logic product;
      logic lookup;
      logic index;
      logic fold3;
      logic fold2;
      logic fold1;
   } stage_load_type;

   typedef logic [TAN_W-1:0] tan_tab_type [TAN_ENTRIES];

   // Truncating unsigned quotient by shift and subtract; it only runs while
   // the constant table below is built.
   function automatic longint unsigned const_udiv(input longint unsigned num,
                                                  input longint unsigned den);
      longint unsigned quo;
      longint unsigned rem;
      int              b;
      quo = '0;
      rem = '0;
      for (b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // Tangent over a quarter turn in Q7.16, from Q30 Taylor series of sine
   // and cosine with truncating steps, saturated at 64.0.
   function automatic tan_tab_type build_tan_tab();
      tan_tab_type     tab;
      longint unsigned th;
      longint unsigned x2;
      longint unsigned ts;
      longint unsigned tc;
      longint unsigned t;
      longint          s;
      longint          c;
      int unsigned     k;
      int unsigned     n;
      for (k = 0; k < TAN_ENTRIES; k++) begin
         th = (longint'(k) * HALF_PI_Q30) / TAN_ENTRIES;
         x2 = (th * th) >> 30;
         ts = th;
         tc = ONE_Q30;
         s  = $signed(th);
         c  = $signed(ONE_Q30);
         for (n = 1; n <= 12; n++) begin
            ts = const_udiv((ts * x2) >> 30, longint'((2 * n) * (2 * n + 1)));
            tc = const_udiv((tc * x2) >> 30, longint'((2 * n - 1) * (2 * n)));
            if (n[0]) begin
               s = s - $signed(ts);
               c = c - $signed(tc);
            end else begin
               s = s + $signed(ts);
               c = c + $signed(tc);
            end
         end
         if (s < 0) s = 0;
         if (c <= 0) begin
            t = TAN_LIMIT;
         end else begin
            t = const_udiv($unsigned(s) << 16, $unsigned(c));
            if (t > TAN_LIMIT) t = TAN_LIMIT;
         end
         tab[k] = TAN_W'(t);
      end
      return tab;
   endfunction

endpackage

[rtl/lhl_stream_if.sv]
// Valid/ready channel interfaces of the leg height leveller, one for the
// request words and one for the response words. Depends on lhl_pkg.
interface lhl_req_if;
   import lhl_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [ANGLE_W-1:0] roll_angle;
   logic signed [ANGLE_W-1:0] pitch_angle;
   logic [LEG_W-1:0]          leg;
   logic signed [LEN_W-1:0]   leg_x;
   logic signed [LEN_W-1:0]   leg_y;
   logic signed [LEN_W-1:0]   leg_z;

   modport source (output valid, roll_angle, pitch_angle, leg, leg_x, leg_y, leg_z,
                   input ready);
   modport sink (input valid, roll_angle, pitch_angle, leg, leg_x, leg_y, leg_z,
                 output ready);
endinterface

interface lhl_rsp_if;
   import lhl_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [LEN_W-1:0] new_z;
   logic                    clamped;

   modport source (output valid, new_z, clamped, input ready);
   modport sink (input valid, new_z, clamped, output ready);
endinterface

[rtl/lhl_angle_fold.sv]
// Angle pipeline: wraps pitch and roll into one turn, folds them onto a
// quarter turn and forms the tangent table index. Depends on lhl_pkg.
module lhl_angle_fold import lhl_pkg::*; (
   input  logic                      clock,
   input  stage_load_type            ld,
   input  logic signed [ANGLE_W-1:0] pitch_angle,
   input  logic signed [ANGLE_W-1:0] roll_angle,
   output logic [IDX_W-1:0]          pitch_idx,
   output logic [IDX_W-1:0]          roll_idx,
   output logic                      pitch_neg,
   output logic                      roll_neg
);

   logic signed [WRAP_W-1:0] biased   [NUM_LANES];
   logic [WRAP_W-2:0]        pos      [NUM_LANES];
   logic [RED_W-1:0]         red_in   [NUM_LANES];
   logic [RED_W-1:0]         red_ff   [NUM_LANES];
   logic [TURN_W-1:0]        turn_in  [NUM_LANES];
   logic [TURN_W-1:0]        turn_ff  [NUM_LANES];
   logic [MAG_W-1:0]         mag_in   [NUM_LANES];
   logic [MAG_W-1:0]         mag_ff   [NUM_LANES];
   logic                     neg_in   [NUM_LANES];
   logic                     neg_ff   [NUM_LANES];
   logic [IDX_PROD_W-1:0]    prod     [NUM_LANES];
   logic [IDX_W-1:0]         idx_in   [NUM_LANES];
   logic [IDX_W-1:0]         idx_ff   [NUM_LANES];

   // Biasing by whole turns makes the angle positive; roll also loses a
   // half turn here. The biased pitch can reach past four turns, so four or
   // two whole turns come off first, leaving less than two turns.
   always_comb begin
      biased[LANE_PITCH] = WRAP_W'(pitch_angle) + WRAP_W'(PITCH_BIAS);
      biased[LANE_ROLL]  = WRAP_W'(roll_angle) + WRAP_W'(ROLL_BIAS);
      for (int l = 0; l < NUM_LANES; l++) begin
         pos[l] = biased[l][WRAP_W-2:0];
         priority if (pos[l] >= (WRAP_W-1)'(FOUR_TURNS)) begin
            red_in[l] = RED_W'(pos[l] - (WRAP_W-1)'(FOUR_TURNS));
         end else if (pos[l] >= (WRAP_W-1)'(TWO_TURNS)) begin
            red_in[l] = RED_W'(pos[l] - (WRAP_W-1)'(TWO_TURNS));
         end else begin
            red_in[l] = RED_W'(pos[l]);
         end
      end
   end

   always_comb begin
      for (int l = 0; l < NUM_LANES; l++) begin
         if (red_ff[l] >= RED_W'(FULL_TURN)) begin
            turn_in[l] = TURN_W'(red_ff[l] - RED_W'(FULL_TURN));
         end else begin
            turn_in[l] = TURN_W'(red_ff[l]);
         end
      end
   end

   // The turn position splits into four quadrants; the magnitude is the
   // distance to the nearer horizontal and the sign that of the tangent.
   always_comb begin
      for (int l = 0; l < NUM_LANES; l++) begin
         priority if (turn_ff[l] <= TURN_W'(QUARTER_TURN)) begin
            mag_in[l] = MAG_W'(turn_ff[l]);
            neg_in[l] = 1'b0;
         end else if (turn_ff[l] <= TURN_W'(HALF_TURN)) begin
            mag_in[l] = MAG_W'(TURN_W'(HALF_TURN) - turn_ff[l]);
            neg_in[l] = 1'b1;
         end else if (turn_ff[l] < TURN_W'(HALF_TURN + QUARTER_TURN)) begin
            mag_in[l] = MAG_W'(turn_ff[l] - TURN_W'(HALF_TURN));
            neg_in[l] = 1'b0;
         end else begin
            mag_in[l] = MAG_W'(TURN_W'(FULL_TURN) - turn_ff[l]);
            neg_in[l] = 1'b1;
         end
      end
   end

   always_comb begin
      for (int l = 0; l < NUM_LANES; l++) begin
         prod[l]   = IDX_PROD_W'(mag_ff[l]) * IDX_PROD_W'(IDX_MUL);
         idx_in[l] = prod[l][IDX_SHIFT +: IDX_W];
      end
   end

   always_ff @(posedge clock) begin
      for (int l = 0; l < NUM_LANES; l++) begin
         if (ld.fold1) red_ff[l] <= red_in[l];
         if (ld.fold2) turn_ff[l] <= turn_in[l];
         if (ld.fold3) begin
            mag_ff[l] <= mag_in[l];
            neg_ff[l] <= neg_in[l];
         end
         if (ld.index) idx_ff[l] <= idx_in[l];
      end
   end

   assign pitch_idx = idx_ff[LANE_PITCH];
   assign roll_idx  = idx_ff[LANE_ROLL];
   assign pitch_neg = neg_ff[LANE_PITCH];
   assign roll_neg  = neg_ff[LANE_ROLL];

endmodule

[rtl/lhl_tan_rom.sv]
// Tangent ROM with two registered read ports and saturation at ninety
// degrees. Depends on lhl_pkg for the table builder.
module lhl_tan_rom import lhl_pkg::*; (
   input  logic             clock,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] pitch_idx,
   input  logic [IDX_W-1:0] roll_idx,
   output logic [TAN_W-1:0] pitch_tan,
   output logic [TAN_W-1:0] roll_tan
);

   localparam tan_tab_type TAN_TAB = build_tan_tab();

   logic [IDX_W-1:0] idx      [NUM_LANES];
   logic [TAN_W-1:0] data_ff  [NUM_LANES];
   logic             sat_ff   [NUM_LANES];
   logic [TAN_W-1:0] tan_out  [NUM_LANES];

   assign idx[LANE_PITCH] = pitch_idx;
   assign idx[LANE_ROLL]  = roll_idx;

   always_ff @(posedge clock) begin
      for (int l = 0; l < NUM_LANES; l++) begin
         if (rd_en) begin
            data_ff[l] <= TAN_TAB[idx[l][TAB_AW-1:0]];
            sat_ff[l]  <= (idx[l] >= IDX_W'(TAN_ENTRIES));
         end
      end
   end

   always_comb begin
      for (int l = 0; l < NUM_LANES; l++) begin
         tan_out[l] = sat_ff[l] ? TAN_W'(TAN_LIMIT) : data_ff[l];
      end
   end

   assign pitch_tan = tan_out[LANE_PITCH];
   assign roll_tan  = tan_out[LANE_ROLL];

endmodule

[rtl/lhl_lever.sv]
// Lever pipeline: lever arms with per-leg signs, tangent products, height
// sum and clamp to floor and ceiling. Depends on lhl_pkg.
module lhl_lever import lhl_pkg::*; (
   input  logic                      clock,
   input  stage_load_type            ld,
   input  logic signed [LEN_W-1:0]   z_floor,
   input  logic signed [LEN_W-1:0]   z_ceiling,
   input  logic signed [REACH_W-1:0] reach_offset,
   input  logic [LEG_W-1:0]          leg,
   input  logic signed [LEN_W-1:0]   leg_x,
   input  logic signed [LEN_W-1:0]   leg_y,
   input  logic signed [LEN_W-1:0]   leg_z,
   input  logic                      pitch_neg,
   input  logic                      roll_neg,
   input  logic [TAN_W-1:0]          pitch_tan,
   input  logic [TAN_W-1:0]          roll_tan,
   output logic signed [LEN_W-1:0]   new_z,
   output logic                      clamped
);

   localparam int Z_DEPTH = 7;

   logic [LEG_W-1:0]        leg1_ff, leg2_ff, leg3_ff;
   logic signed [ARM_W-1:0] ax_in, ay_in;
   logic signed [ARM_W-1:0] ax1_ff, ax2_ff, ax3_ff, ax4_ff, ax5_ff;
   logic signed [ARM_W-1:0] ay1_ff, ay2_ff, ay3_ff, ay4_ff, ay5_ff;
   logic                    flip_x, flip_y;
   logic signed [ARM_W-1:0] sx_in, sy_in;
   logic signed [PROD_W-1:0] px_in, py_in, px_ff, py_ff;
   logic signed [SUM_W-1:0] sum_in, sum_ff;
   logic signed [HT_W-1:0]  height_in, height_ff;
   logic signed [LEN_W-1:0] z_ff [Z_DEPTH];
   logic [Z_DEPTH-1:0]      z_ld;
   logic signed [LEN_W-1:0] new_z_in, new_z_ff;
   logic                    clamped_in, clamped_ff;

   assign ax_in = ARM_W'(leg_x) + ARM_W'(reach_offset);
   assign ay_in = ARM_W'(leg_y) + ARM_W'(reach_offset);

   // Front legs take pitch positive, legs 0 and 3 take roll positive; the
   // sign of each tangent is folded into its arm as well.
   assign flip_x = leg3_ff[1] ^ pitch_neg;
   assign flip_y = leg3_ff[1] ^ leg3_ff[0] ^ roll_neg;
   assign sx_in  = flip_x ? -ax3_ff : ax3_ff;
   assign sy_in  = flip_y ? -ay3_ff : ay3_ff;

   assign px_in = PROD_W'(ax5_ff) * PROD_W'($signed({1'b0, pitch_tan}));
   assign py_in = PROD_W'(ay5_ff) * PROD_W'($signed({1'b0, roll_tan}));

   assign sum_in    = SUM_W'(px_ff) + SUM_W'(py_ff);
   assign height_in = HT_W'(z_ff[Z_DEPTH-1]) + HT_W'($signed(sum_ff[SUM_W-1:FRAC_BITS]));

   // Floor is tested first, so a floor above the ceiling wins.
   always_comb begin
      priority if (height_ff < HT_W'(z_floor)) begin
         new_z_in   = z_floor;
         clamped_in = 1'b1;
      end else if (height_ff > HT_W'(z_ceiling)) begin
         new_z_in   = z_ceiling;
         clamped_in = 1'b1;
      end else begin
         new_z_in   = LEN_W'(height_ff);
         clamped_in = 1'b0;
      end
   end

   assign z_ld = {ld.sum, ld.product, ld.lookup, ld.index, ld.fold3, ld.fold2, ld.fold1};

   always_ff @(posedge clock) begin
      if (ld.fold1) begin
         leg1_ff <= leg;
         ax1_ff  <= ax_in;
         ay1_ff  <= ay_in;
      end
      if (ld.fold2) begin
         leg2_ff <= leg1_ff;
         ax2_ff  <= ax1_ff;
         ay2_ff  <= ay1_ff;
      end
      if (ld.fold3) begin
         leg3_ff <= leg2_ff;
         ax3_ff  <= ax2_ff;
         ay3_ff  <= ay2_ff;
      end
      if (ld.index) begin
         ax4_ff <= sx_in;
         ay4_ff <= sy_in;
      end
      if (ld.lookup) begin
         ax5_ff <= ax4_ff;
         ay5_ff <= ay4_ff;
      end
      if (ld.product) begin
         px_ff <= px_in;
         py_ff <= py_in;
      end
      if (ld.sum) sum_ff <= sum_in;
      if (ld.height) height_ff <= height_in;
      if (ld.result) begin
         new_z_ff   <= new_z_in;
         clamped_ff <= clamped_in;
      end
      if (z_ld[0]) z_ff[0] <= leg_z;
      for (int i = 1; i < Z_DEPTH; i++) begin
         if (z_ld[i]) z_ff[i] <= z_ff[i-1];
      end
   end

   assign new_z   = new_z_ff;
   assign clamped = clamped_ff;

endmodule

[rtl/leg_height_leveler_core.sv]
// Top level of the leg height leveller: configuration registers, pipeline
// valid and stall control, and the three datapath parts.
// Pipeline: nine register stages from request acceptance to response valid.
// Throughput: one word per cycle while responses are taken; every stage holds
//    one word and stalls only when it is full and the stage after it cannot move.
// Reset: synchronous; empties the pipeline and restores the three registers
//    to floor -220 mm, ceiling -80 mm and reach 70 mm. The tangent ROM is a
//    constant, so no clearing pass follows reset.
module leg_height_leveler_core import lhl_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   lhl_req_if.sink              req_ch,
   lhl_rsp_if.source            rsp_ch,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   logic signed [LEN_W-1:0]   z_floor_ff, z_floor_in;
   logic signed [LEN_W-1:0]   z_ceiling_ff, z_ceiling_in;
   logic signed [REACH_W-1:0] reach_offset_ff, reach_offset_in;

   logic [NUM_STAGES-1:0] valid_ff, valid_in, load_vec, valid_up;
   stage_load_type        ld;

   logic [IDX_W-1:0] pitch_idx, roll_idx;
   logic             pitch_neg, roll_neg;
   logic [TAN_W-1:0] pitch_tan, roll_tan;

   // Configuration writes. The registers must be written only while the
   // pipeline is empty, so each stage may read them directly; the block does
   // not enforce it, the user must. An index beyond the three registers is dropped.
   always_comb begin
      z_floor_in      = z_floor_ff;
      z_ceiling_in    = z_ceiling_ff;
      reach_offset_in = reach_offset_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_Z_FLOOR:      z_floor_in      = $signed(csr_wdata);
            CSR_Z_CEILING:    z_ceiling_in    = $signed(csr_wdata);
            CSR_REACH_OFFSET: reach_offset_in = $signed(csr_wdata[REACH_W-1:0]);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         z_floor_ff      <= LEN_W'(Z_FLOOR_RESET);
         z_ceiling_ff    <= LEN_W'(Z_CEILING_RESET);
         reach_offset_ff <= REACH_W'(REACH_OFFSET_RESET);
      end else begin
         z_floor_ff      <= z_floor_in;
         z_ceiling_ff    <= z_ceiling_in;
         reach_offset_ff <= reach_offset_in;
      end
   end

   // Stall control. A stage loads when it is empty or when the stage after
   // it loads as well; the last stage is the response register and loads
   // when the response is taken. Bubbles are squeezed out, so a stalled
   // response does not stop the request side until every stage is full.
   always_comb begin
      load_vec[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_ch.ready;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         load_vec[i] = !valid_ff[i] || load_vec[i+1];
      end
   end

   always_comb begin
      valid_up = {valid_ff[NUM_STAGES-2:0], req_ch.valid};
      for (int i = 0; i < NUM_STAGES; i++) begin
         valid_in[i] = load_vec[i] ? valid_up[i] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign ld.fold1   = load_vec[0];
   assign ld.fold2   = load_vec[1];
   assign ld.fold3   = load_vec[2];
   assign ld.index   = load_vec[3];
   assign ld.lookup  = load_vec[4];
   assign ld.product = load_vec[5];
   assign ld.sum     = load_vec[6];
   assign ld.height  = load_vec[7];
   assign ld.result  = load_vec[8];

   assign req_ch.ready = load_vec[0];
   assign rsp_ch.valid = valid_ff[NUM_STAGES-1];

   // Stages one to four: wrap, fold and table index of both angles.
   lhl_angle_fold u_angle_fold (
      .clock       (clock),
      .ld          (ld),
      .pitch_angle (req_ch.pitch_angle),
      .roll_angle  (req_ch.roll_angle),
      .pitch_idx   (pitch_idx),
      .roll_idx    (roll_idx),
      .pitch_neg   (pitch_neg),
      .roll_neg    (roll_neg)
   );

   // Stage five: tangent lookup, both angles in the same cycle.
   lhl_tan_rom u_tan_rom (
      .clock     (clock),
      .rd_en     (ld.lookup),
      .pitch_idx (pitch_idx),
      .roll_idx  (roll_idx),
      .pitch_tan (pitch_tan),
      .roll_tan  (roll_tan)
   );

   // Arms run alongside stages one to five; products, sum, height and
   // clamp take stages six to nine.
   lhl_lever u_lever (
      .clock        (clock),
      .ld           (ld),
      .z_floor      (z_floor_ff),
      .z_ceiling    (z_ceiling_ff),
      .reach_offset (reach_offset_ff),
      .leg          (req_ch.leg),
      .leg_x        (req_ch.leg_x),
      .leg_y        (req_ch.leg_y),
      .leg_z        (req_ch.leg_z),
      .pitch_neg    (pitch_neg),
      .roll_neg     (roll_neg),
      .pitch_tan    (pitch_tan),
      .roll_tan     (roll_tan),
      .new_z        (rsp_ch.new_z),
      .clamped      (rsp_ch.clamped)
   );

endmodule

[rtl/lhl_core_checker.sv]
// Port-level checker of the leg height leveller, bound to the top level.
// Depends on lhl_pkg and the assertion macros header.
`include "leg_height_leveler_core_assert.svh"

module lhl_core_checker import lhl_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [LEN_W-1:0] rsp_new_z,
   input logic             rsp_clamped
);

   logic [OUTSTANDING_W-1:0] outst_ff, outst_in;

   // Words accepted but not yet delivered.
   always_comb begin
      outst_in = outst_ff;
      if (req_valid && req_ready) outst_in = outst_in + OUTSTANDING_W'(1);
      if (rsp_valid && rsp_ready) outst_in = outst_in - OUTSTANDING_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outst_ff <= '0;
      end else begin
         outst_ff <= outst_in;
      end
   end

   `LHL_ASSERT_NXT(a_stall_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_new_z) && $stable(rsp_clamped))
   `LHL_ASSERT_NXT_ALWAYS(a_reset_empties, clock, reset, !rsp_valid)
   `LHL_ASSERT_IMP(a_no_invented, clock, reset, rsp_valid, outst_ff != '0)
   `LHL_ASSERT_IMP(a_capacity, clock, reset, 1'b1, outst_ff <= OUTSTANDING_W'(NUM_STAGES))

endmodule

bind leg_height_leveler_core lhl_core_checker u_core_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_new_z   (rsp_ch.new_z),
   .rsp_clamped (rsp_ch.clamped)
);

[verif/testbench.sv]
// Self-checking testbench of leg_height_leveler_core: a directed table and
// random words against a built-in height predictor, under varied idling.
// Depends on lhl_pkg and the channel interfaces in lhl_stream_if.sv.
`timescale 1ns / 1ps

module testbench;
   import lhl_pkg::*;

   // Timing of the run.
   localparam int HALF_PERIOD    = 6;
   localparam int CLOCK_PERIOD   = 2 * HALF_PERIOD;
   localparam int RESET_CYCLES   = 12;
   localparam int LATENCY        = NUM_STAGES;
   localparam int TIMEOUT_CYCLES = 200000;
   localparam int DRAIN_CYCLES   = 5000;

   // Leg numbering around the body.
   localparam logic [LEG_W-1:0] LEG_FRONT_LEFT  = 2'd0;
   localparam logic [LEG_W-1:0] LEG_FRONT_RIGHT = 2'd1;
   localparam logic [LEG_W-1:0] LEG_REAR_RIGHT  = 2'd2;
   localparam logic [LEG_W-1:0] LEG_REAR_LEFT   = 2'd3;

   // No register sits at this index, so a write to it must change nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   // Register values that the block wakes up with.
   localparam longint FLOOR_AT_RESET   = -3520;
   localparam longint CEILING_AT_RESET = -1280;
   localparam longint REACH_AT_RESET   = 1120;

   typedef longint unsigned u64_t;

   typedef struct packed {
      logic signed [ANGLE_W-1:0] roll_angle;
      logic signed [ANGLE_W-1:0] pitch_angle;
      logic [LEG_W-1:0]          leg;
      logic signed [LEN_W-1:0]   leg_x;
      logic signed [LEN_W-1:0]   leg_y;
      logic signed [LEN_W-1:0]   leg_z;
   } leg_word_t;

   typedef struct packed {
      logic signed [LEN_W-1:0] new_z;
      logic                    clamped;
   } height_t;

   // One row of the directed table. Where typed is set, the height is read
   // straight off the row; otherwise the predictor supplies it.
   typedef struct packed {
      leg_word_t word;
      logic      typed;
      height_t   height;
   } stim_row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   lhl_req_if req_if ();
   lhl_rsp_if rsp_if ();

   leg_height_leveler_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #(HALF_PERIOD) clock = 1'b1;
      #(HALF_PERIOD) clock = 1'b0;
   end

   // Shadow copy of the three registers, kept in step with every write.
   longint floor_shadow   = FLOOR_AT_RESET;
   longint ceiling_shadow = CEILING_AT_RESET;
   longint reach_shadow   = REACH_AT_RESET;

   // Tangents over a quarter turn in Q7.16, one entry per table slot.
   longint tangent_rom [TAN_ENTRIES];

   // Heights that the block owes us, oldest first.
   height_t pending_heights [$];
   int      fault_count = 0;

   // Idling controls. The percentages give the chance, per cycle, that the
   // sender leaves a gap before its next word or that the receiver stalls.
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   bit pressure_on    = 1'b0;

   logic rsp_ready_q   = 1'b0;
   int   hold_counter  = 0;
   assign rsp_if.ready = rsp_ready_q;

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // Sine and cosine by thirteen-term Taylor series in Q30, every product and
   // division truncating, then their ratio saturated at 64.0.
   task automatic fill_tangent_rom();
      u64_t   angle_q30;
      u64_t   angle_sq;
      u64_t   term_s;
      u64_t   term_c;
      u64_t   ratio;
      longint sine;
      longint cosine;
      int     k;
      int     n;
      for (k = 0; k < TAN_ENTRIES; k++) begin
         angle_q30 = (u64_t'(k) * HALF_PI_Q30) / u64_t'(TAN_ENTRIES);
         angle_sq  = (angle_q30 * angle_q30) >> 30;
         term_s    = angle_q30;
         term_c    = ONE_Q30;
         sine      = longint'(angle_q30);
         cosine    = longint'(ONE_Q30);
         for (n = 1; n <= 12; n++) begin
            term_s = ((term_s * angle_sq) >> 30) / u64_t'((2 * n) * (2 * n + 1));
            term_c = ((term_c * angle_sq) >> 30) / u64_t'((2 * n - 1) * (2 * n));
            if (n % 2 == 1) begin
               sine   = sine - longint'(term_s);
               cosine = cosine - longint'(term_c);
            end else begin
               sine   = sine + longint'(term_s);
               cosine = cosine + longint'(term_c);
            end
         end
         if (sine < 0) sine = 0;
         if (cosine <= 0) begin
            ratio = u64_t'(TAN_LIMIT);
         end else begin
            ratio = (u64_t'(sine) << 16) / u64_t'(cosine);
            if (ratio > u64_t'(TAN_LIMIT)) ratio = u64_t'(TAN_LIMIT);
         end
         tangent_rom[k] = longint'(ratio);
      end
   endtask

   // Brings any angle into the half-open span above minus half a turn.
   function automatic longint wrap_turn(input longint angle);
      longint folded;
      folded = (angle + 3 * FULL_TURN) % FULL_TURN;
      if (folded > HALF_TURN) folded = folded - FULL_TURN;
      return folded;
   endfunction

   // Beyond a quarter turn the angle is mirrored and the sign flips. A full
   // quarter turn runs off the end of the table and saturates.
   function automatic longint tangent_of(input longint angle);
      bit     negative;
      longint mag;
      longint slot;
      longint tangent;
      negative = (angle < 0);
      mag      = negative ? -angle : angle;
      if (mag > QUARTER_TURN) begin
         mag      = HALF_TURN - mag;
         negative = !negative;
      end
      slot    = (mag * TAN_ENTRIES) / QUARTER_TURN;
      tangent = (slot >= TAN_ENTRIES) ? longint'(TAN_LIMIT) : tangent_rom[slot];
      return negative ? -tangent : tangent;
   endfunction

   function automatic height_t predict_height(input leg_word_t w);
      longint  arm_x;
      longint  arm_y;
      longint  lever;
      longint  level_z;
      height_t h;
      arm_x = longint'(w.leg_x) + reach_shadow;
      arm_y = longint'(w.leg_y) + reach_shadow;
      // Pitch lifts the front pair; roll lifts the front-left and rear-left pair.
      if (w.leg == LEG_REAR_RIGHT || w.leg == LEG_REAR_LEFT) arm_x = -arm_x;
      if (w.leg == LEG_FRONT_RIGHT || w.leg == LEG_REAR_RIGHT) arm_y = -arm_y;
      lever = arm_x * tangent_of(wrap_turn(longint'(w.pitch_angle)))
            + arm_y * tangent_of(wrap_turn(longint'(w.roll_angle) - HALF_TURN));
      // The arithmetic shift floors towards minus infinity.
      level_z   = longint'(w.leg_z) + (lever >>> 16);
      h.clamped = 1'b1;
      if (level_z < floor_shadow) level_z = floor_shadow;
      else if (level_z > ceiling_shadow) level_z = ceiling_shadow;
      else h.clamped = 1'b0;
      h.new_z = level_z[LEN_W-1:0];
      return h;
   endfunction

   // ---------------------------------------------------------------------
   // Random words
   // ---------------------------------------------------------------------

   function automatic int rand_span(input int lo, input int hi);
      return lo + int'($urandom_range(hi - lo));
   endfunction

   // A quarter of the angles are anywhere in range, a quarter sit a step or
   // two from a multiple of ninety degrees, and the rest lie near the
   // given centre, as a body that is almost level would report them.
   function automatic logic signed [ANGLE_W-1:0] random_angle(input int centre);
      int angle;
      case ($urandom_range(3))
         0: angle = rand_span(-FULL_TURN, FULL_TURN);
         1: angle = QUARTER_TURN * rand_span(-4, 4) + rand_span(-2, 2);
         default: angle = centre + rand_span(-2560, 2560);
      endcase
      if (angle > FULL_TURN) angle = FULL_TURN;
      if (angle < -FULL_TURN) angle = -FULL_TURN;
      return angle[ANGLE_W-1:0];
   endfunction

   function automatic logic signed [LEN_W-1:0] random_length(input int lo, input int hi);
      int length;
      length = $urandom_range(1) ? rand_span(lo, hi) : rand_span(-32768, 32767);
      return length[LEN_W-1:0];
   endfunction

   function automatic leg_word_t random_word();
      leg_word_t w;
      // A level body reads a roll of half a turn either way.
      w.roll_angle  = random_angle($urandom_range(1) ? HALF_TURN : -HALF_TURN);
      w.pitch_angle = random_angle(0);
      w.leg         = LEG_W'($urandom_range(3));
      w.leg_x       = random_length(-4000, 4000);
      w.leg_y       = random_length(-4000, 4000);
      w.leg_z       = random_length(-4500, -500);
      return w;
   endfunction

   // ---------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------

   // Called just after a rising edge. Each word is held until the block
   // takes it; ready is sampled at the falling edge before the deciding
   // rising edge, when nothing in the design can still change.
   task automatic offer_word(input leg_word_t w, input logic typed, input height_t height);
      bit      taken;
      height_t due;
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.roll_angle  <= w.roll_angle;
      req_if.pitch_angle <= w.pitch_angle;
      req_if.leg         <= w.leg;
      req_if.leg_x       <= w.leg_x;
      req_if.leg_y       <= w.leg_y;
      req_if.leg_z       <= w.leg_z;
      due   = typed ? height : predict_height(w);
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = req_if.ready;
         @(posedge clock);
      end
      pending_heights.push_back(due);
   endtask

   // The enable drops in the step after the write, so back-to-back calls
   // never drive it twice in one time step.
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_Z_FLOOR:      floor_shadow   = longint'($signed(data));
         CSR_Z_CEILING:    ceiling_shadow = longint'($signed(data));
         CSR_REACH_OFFSET: reach_shadow   = longint'($signed(data[REACH_W-1:0]));
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_registers(input logic [CSR_W-1:0] floor_word,
                                input logic [CSR_W-1:0] ceiling_word,
                                input logic [CSR_W-1:0] reach_word);
      write_register(CSR_Z_FLOOR, floor_word);
      write_register(CSR_Z_CEILING, ceiling_word);
      write_register(CSR_REACH_OFFSET, reach_word);
   endtask

   // Waits for every owed height, then lets the pipeline settle before the
   // registers may be touched again.
   task automatic settle();
      while (pending_heights.size() != 0) @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   task automatic random_burst(input int count);
      int i;
      for (i = 0; i < count; i++) offer_word(random_word(), 1'b0, '0);
      req_if.valid <= 1'b0;
      settle();
   endtask

   // ---------------------------------------------------------------------
   // Receiver
   // ---------------------------------------------------------------------

   // Under pressure the receiver holds off by its hold counter while the sender
   // keeps offering, so the pipeline fills and has to push back on its input.
   always @(posedge clock) begin
      hold_counter <= (hold_counter == 99) ? 0 : hold_counter + 1;
      if (pressure_on) rsp_ready_q <= (hold_counter >= 70);
      else rsp_ready_q <= ($urandom_range(99) >= recv_stall_pct);
   end

   // ---------------------------------------------------------------------
   // Result check
   // ---------------------------------------------------------------------

   always @(negedge clock) begin : result_check
      height_t due;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (pending_heights.size() == 0) begin
            fault_count++;
            $display("%0t: unexpected word, new_z %0d clamped %0b",
                     $time, rsp_if.new_z, rsp_if.clamped);
         end else begin
            due = pending_heights.pop_front();
            if (rsp_if.new_z !== due.new_z) begin
               fault_count++;
               $display("%0t: new_z expected %0d, got %0d", $time, due.new_z, rsp_if.new_z);
            end
            if (rsp_if.clamped !== due.clamped) begin
               fault_count++;
               $display("%0t: clamped expected %0b, got %0b",
                        $time, due.clamped, rsp_if.clamped);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Directed table
   // ---------------------------------------------------------------------

   // The first eleven rows hold the body level, either directly or through
   // a whole turn or half a turn, so every tangent is zero and the height
   // passes straight to the clamp against the reset bounds. The rest tilt
   // the body to exactly ninety degrees, to just either side of it, to the
   // far ends of the angle range, and take each leg in turn.
   localparam int DIRECTED_ROWS = 23;
   stim_row_t directed [DIRECTED_ROWS] = '{
      '{'{HALF_TURN, 0, LEG_FRONT_LEFT, 0, 0, -2000}, 1'b1, '{-2000, 1'b0}},
      '{'{HALF_TURN, 0, LEG_FRONT_LEFT, 0, 0, -3520}, 1'b1, '{-3520, 1'b0}},
      '{'{HALF_TURN, 0, LEG_FRONT_LEFT, 0, 0, -1280}, 1'b1, '{-1280, 1'b0}},
      '{'{HALF_TURN, 0, LEG_FRONT_LEFT, 0, 0, -3521}, 1'b1, '{-3520, 1'b1}},
      '{'{HALF_TURN, 0, LEG_FRONT_LEFT, 0, 0, -1279}, 1'b1, '{-1280, 1'b1}},
      '{'{HALF_TURN, 0, LEG_FRONT_RIGHT, 0, 0, -32768}, 1'b1, '{-3520, 1'b1}},
      '{'{HALF_TURN, 0, LEG_REAR_RIGHT, 0, 0, 32767}, 1'b1, '{-1280, 1'b1}},
      '{'{-HALF_TURN, FULL_TURN, LEG_FRONT_LEFT, 32767, -32768, -2400}, 1'b1, '{-2400, 1'b0}},
      '{'{HALF_TURN, -FULL_TURN, LEG_REAR_LEFT, -32768, 32767, -1500}, 1'b1, '{-1500, 1'b0}},
      '{'{0, HALF_TURN, LEG_FRONT_RIGHT, 3000, -3000, -3000}, 1'b1, '{-3000, 1'b0}},
      '{'{FULL_TURN, -HALF_TURN, LEG_REAR_RIGHT, -3000, 3000, -1300}, 1'b1, '{-1300, 1'b0}},
      '{'{HALF_TURN, QUARTER_TURN, LEG_FRONT_LEFT, 0, 0, -2000}, 1'b0, '0},
      '{'{HALF_TURN, -QUARTER_TURN, LEG_FRONT_RIGHT, 0, 0, -2000}, 1'b0, '0},
      '{'{HALF_TURN + QUARTER_TURN, 0, LEG_REAR_RIGHT, 100, -200, -2500}, 1'b0, '0},
      '{'{QUARTER_TURN, 0, LEG_REAR_LEFT, -100, 200, -2500}, 1'b0, '0},
      '{'{HALF_TURN, QUARTER_TURN - 1, LEG_FRONT_LEFT, -32768, 32767, -2000}, 1'b0, '0},
      '{'{HALF_TURN, QUARTER_TURN + 1, LEG_FRONT_RIGHT, -32768, 32767, -2000}, 1'b0, '0},
      '{'{-QUARTER_TURN, 3 * QUARTER_TURN, LEG_REAR_RIGHT, 32767, 32767, 32767}, 1'b0, '0},
      '{'{-FULL_TURN, -3 * QUARTER_TURN, LEG_REAR_LEFT, -32768, -32768, -32768}, 1'b0, '0},
      '{'{HALF_TURN - 640, 640, LEG_FRONT_LEFT, 1500, -1200, -2000}, 1'b0, '0},
      '{'{HALF_TURN - 640, 640, LEG_FRONT_RIGHT, 1500, -1200, -2000}, 1'b0, '0},
      '{'{HALF_TURN - 640, 640, LEG_REAR_RIGHT, 1500, -1200, -2000}, 1'b0, '0},
      '{'{HALF_TURN - 640, 640, LEG_REAR_LEFT, 1500, -1200, -2000}, 1'b0, '0}
   };

   // ---------------------------------------------------------------------
   // Sequence of the run
   // ---------------------------------------------------------------------

   initial begin : main_sequence
      int row;
      int i;
      int floor_value;
      req_if.valid       <= 1'b0;
      req_if.roll_angle  <= '0;
      req_if.pitch_angle <= '0;
      req_if.leg         <= '0;
      req_if.leg_x       <= '0;
      req_if.leg_y       <= '0;
      req_if.leg_z       <= '0;
      csr_we             <= 1'b0;
      csr_index          <= '0;
      csr_wdata          <= '0;
      fill_tangent_rom();

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words against the reset registers, back to back.
      for (row = 0; row < DIRECTED_ROWS; row++)
         offer_word(directed[row].word, directed[row].typed, directed[row].height);
      req_if.valid <= 1'b0;
      settle();

      // Reset registers, no idling on either side.
      random_burst(110);

      // Bounds wide open and the most negative reach; the sender idles.
      // Only a sum that leaves sixteen bits can be clamped here.
      set_registers(16'h8000, 16'h7FFF, 16'hE000);
      send_idle_pct = 74;
      random_burst(110);

      // Floor above the ceiling: the floor test wins whenever both apply.
      // The receiver stalls.
      set_registers(16'sd1000, -16'sd1000, 16'($urandom_range(16'hFFFF)));
      send_idle_pct  = 0;
      recv_stall_pct = 74;
      random_burst(110);

      // Narrow band and the largest reach; both sides idle now and then.
      floor_value = rand_span(-5000, -2000);
      set_registers(16'(floor_value), 16'(floor_value + rand_span(0, 3000)), 16'h1FFF);
      send_idle_pct  = 27;
      recv_stall_pct = 27;
      random_burst(110);

      // Long holds at the receiver with the sender offering every cycle.
      set_registers(16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
                    16'($urandom_range(16'hFFFF)));
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      pressure_on    = 1'b1;
      random_burst(140);
      pressure_on = 1'b0;

      // Random bounds, then a write to the spare index that must be ignored.
      floor_value = rand_span(-6000, 0);
      set_registers(16'(floor_value), 16'(floor_value + rand_span(-500, 4000)),
                    16'($urandom_range(16'hFFFF)));
      write_register(CSR_SPARE, 16'($urandom_range(16'hFFFF)));
      send_idle_pct  = 27;
      recv_stall_pct = 27;
      random_burst(110);

      // Back to the reset values by writing them.
      set_registers(16'(FLOOR_AT_RESET), 16'(CEILING_AT_RESET), 16'(REACH_AT_RESET));
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      random_burst(110);

      for (i = 0; i < DRAIN_CYCLES && pending_heights.size() != 0; i++) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
      if (pending_heights.size() != 0) begin
         fault_count++;
         $display("%0t: %0d words never arrived", $time, pending_heights.size());
      end

      if (fault_count == 0) begin
         $display("leg_height_leveler_core verification clean");
      end else begin
         $display("leg_height_leveler_core verification failed");
      end
      $finish;
   end

   // Guards against a block that hangs.
   initial begin
      #(TIMEOUT_CYCLES * CLOCK_PERIOD);
      $display("leg_height_leveler_core verification failed");
      $finish;
   end

endmodule
